// ===== design/positional_list_with_capacity_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the positional list design.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_WITH_CAPACITY_TOP_MACROS_SVH
`define POSITIONAL_LIST_WITH_CAPACITY_TOP_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define PLWC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define PLWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/plwc_pkg.sv =====
// ----------------------------------------------------------------------------
// plwc_pkg
// Types and constants of the positional list with a capacity figure.
// ----------------------------------------------------------------------------
package plwc_pkg;

  // Storage geometry.
  localparam int unsigned DEPTH        = 64;
  localparam int unsigned MIN_CAPACITY = 4;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned IDX_W        = $clog2(DEPTH);
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);

  // Fixed field widths of the request and response.
  localparam int unsigned POS_W   = 7;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FCNT_W  = 7;

  // Width used for comparing positions with indexes and counts.
  localparam int unsigned CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REPLACE = 2'd1,
    OP_ACCESS  = 2'd2,
    OP_REMOVE  = 2'd3
  } plwc_op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } plwc_status_e;

  typedef struct packed {
    plwc_op_e           operation;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } plwc_req_t;

  typedef struct packed {
    plwc_status_e       status;
    logic [VALUE_W-1:0] entry_out;
    logic [FCNT_W-1:0]  entry_count;
    logic [FCNT_W-1:0]  capacity_now;
  } plwc_rsp_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins_en;
    logic              rep_en;
    logic              rem_en;
    logic [CMP_W-1:0]  position;
    logic [CMP_W-1:0]  count;
    logic [DATA_W-1:0] value;
  } plwc_cell_ctrl_t;

endpackage

// ===== design/plwc_cell.sv =====
// ----------------------------------------------------------------------------
// plwc_cell
// One list slot: holds an entry and shifts it to or from its neighbors.
// ----------------------------------------------------------------------------
module plwc_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [plwc_pkg::IDX_W-1:0]        index_i,
  input  plwc_pkg::plwc_cell_ctrl_t         ctrl_i,
  input  logic [plwc_pkg::DATA_W-1:0]       left_i,
  input  logic [plwc_pkg::DATA_W-1:0]       right_i,
  output logic [plwc_pkg::DATA_W-1:0]       entry_o,
  output logic [plwc_pkg::DATA_W-1:0]       read_o
);
  import plwc_pkg::*;

  logic [DATA_W-1:0] entry_q, entry_d;
  logic [CMP_W-1:0]  idx;
  logic [CMP_W-1:0]  idx_next;
  logic              hit;

  assign idx      = CMP_W'(index_i);
  assign idx_next = idx + CMP_W'(1);
  assign hit      = (idx == ctrl_i.position);

  // Next entry: shift up on insert, shift down on remove (clearing the old last entry), write on hit.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en) begin
      if (idx > ctrl_i.position && idx <= ctrl_i.count) begin
        entry_d = left_i;
      end else if (hit) begin
        entry_d = ctrl_i.value;
      end
    end else if (ctrl_i.rep_en) begin
      if (hit) begin
        entry_d = ctrl_i.value;
      end
    end else if (ctrl_i.rem_en) begin
      if (idx >= ctrl_i.position && idx_next < ctrl_i.count) begin
        entry_d = right_i;
      end else if (idx_next == ctrl_i.count) begin
        entry_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
  // Only the addressed cell contributes to the read bus.
  assign read_o  = hit ? entry_q : '0;

endmodule

// ===== design/positional_list_with_capacity_top.sv =====
// A response is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the response side does not stall.
// The whole operation happens in the row of cells in the accept cycle.
// Reset clears all entries to zero, the count to zero and the capacity
// figure to its minimum; no clearing pass is needed.
// ----------------------------------------------------------------------------
// positional_list_with_capacity_top
// Ordered list with insert, replace, access and remove at a position.
// ----------------------------------------------------------------------------
`include "positional_list_with_capacity_top_macros.svh"

module positional_list_with_capacity_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  plwc_pkg::plwc_req_t req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output plwc_pkg::plwc_rsp_t rsp_o
);
  import plwc_pkg::*;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cap_q, cap_d;
  logic              rsp_valid_q;
  plwc_rsp_t         rsp_q, rsp_d;
  logic              accept;
  plwc_cell_ctrl_t   ctrl;
  logic [CMP_W-1:0]  pos;
  logic [CMP_W-1:0]  cnt;
  logic              ins_ok, full, other_ok;
  logic [CNT_W:0]    grown;
  logic [CNT_W-1:0]  half;
  logic [DATA_W-1:0] read_data;
  logic [DATA_W-1:0] entries [DEPTH];
  logic [DATA_W-1:0] reads   [DEPTH];

  // A new request is taken unless a finished response is held back.
  assign req_stall_o = rsp_valid_q & rsp_stall_i;
  assign accept      = req_valid_i & ~req_stall_o;

  assign pos      = CMP_W'(req_i.position);
  assign cnt      = CMP_W'(count_q);
  assign ins_ok   = (pos <= cnt);
  assign full     = (count_q == CNT_W'(DEPTH));
  assign other_ok = (pos < cnt);

  // Control broadcast to the cells.
  always_comb begin
    ctrl.ins_en   = accept && req_i.operation == OP_INSERT && ins_ok && !full;
    ctrl.rep_en   = accept && req_i.operation == OP_REPLACE && other_ok;
    ctrl.rem_en   = accept && req_i.operation == OP_REMOVE && other_ok;
    ctrl.position = pos;
    ctrl.count    = cnt;
    ctrl.value    = DATA_W'(req_i.value);
  end

  // Row of cells, each linked to its neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = entries[i+1];
    end
    plwc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .index_i (IDX_W'(i)),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .entry_o (entries[i]),
      .read_o  (reads[i])
    );
  end

  // Read bus: only the addressed cell drives non-zero data.
  always_comb begin
    read_data = '0;
    for (int k = 0; k < DEPTH; k++) begin
      read_data = read_data | reads[k];
    end
  end

  // Count and capacity update, and the response.
  always_comb begin
    count_d = count_q;
    cap_d   = cap_q;
    grown   = {cap_q, 1'b0};
    half    = cap_q >> 1;
    rsp_d   = rsp_q;
    if (accept) begin
      rsp_d.status    = ST_DONE;
      rsp_d.entry_out = '0;
      if (req_i.operation == OP_INSERT) begin
        if (!ins_ok) begin
          rsp_d.status = ST_BAD_POS;
        end else if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          if (count_q >= cap_q) begin
            cap_d = (grown > (CNT_W + 1)'(DEPTH)) ? CNT_W'(DEPTH) : grown[CNT_W-1:0];
          end
          count_d = count_q + CNT_W'(1);
        end
      end else if (!other_ok) begin
        rsp_d.status = ST_BAD_POS;
      end else begin
        rsp_d.entry_out = VALUE_W'(read_data);
        if (req_i.operation == OP_REMOVE) begin
          count_d = count_q - CNT_W'(1);
          if (count_d < (cap_q >> 2)) begin
            cap_d = (half > CNT_W'(MIN_CAPACITY)) ? half : CNT_W'(MIN_CAPACITY);
          end
        end
      end
      rsp_d.entry_count  = FCNT_W'(count_d);
      rsp_d.capacity_now = FCNT_W'(cap_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CNT_W'(MIN_CAPACITY);
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      cap_q   <= cap_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Assertions.
  `PLWC_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CNT_W'(DEPTH), "count above depth")
  `PLWC_ASSERT(a_cap_range, clk_i, rst_ni,
    cap_q >= CNT_W'(MIN_CAPACITY) && cap_q <= CNT_W'(DEPTH), "capacity out of range")
  `PLWC_ASSERT_NEXT(a_rsp_follows, clk_i, rst_ni, accept, rsp_valid_q, "response missing")
  `PLWC_ASSERT_NEXT(a_count_hold, clk_i, rst_ni, !accept, $stable(count_q) && $stable(cap_q),
    "state changed without request")

endmodule

// ===== tb/sv/tb_positional_list_with_capacity_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for positional_list_with_capacity_top
// Sends insert, replace, access and remove requests through the valid/stall
// handshake and checks every response against a list model kept in the bench.
// ----------------------------------------------------------------------------
module tb_positional_list_with_capacity_top;
  import plwc_pkg::*;

  localparam int unsigned DIRECTED_ITEMS = 22;
  localparam int unsigned RANDOM_ITEMS   = 2000;
  localparam int unsigned CALM_ITEMS     = 250;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef enum int unsigned {
    EP_GROW,
    EP_DRAIN,
    EP_MIXED,
    EP_NOISE
  } episode_e;

  // List model: predicts each response and checks the block's answers in order.
  class list_tracker;
    logic [VALUE_W-1:0] slots[DEPTH];
    int unsigned        fill;
    int unsigned        cap;
    plwc_rsp_t          pending[$];
    int unsigned        mismatches;
    int unsigned        op_seen[4];
    int unsigned        status_seen[3];
    int unsigned        peak_fill;
    int unsigned        peak_cap;

    function new();
      foreach (slots[i]) slots[i] = '0;
      fill       = 0;
      cap        = MIN_CAPACITY;
      mismatches = 0;
      peak_fill  = 0;
      peak_cap   = MIN_CAPACITY;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Apply one accepted request to the model and queue the response it implies.
    function void note_request(input plwc_req_t r);
      plwc_rsp_t   exp_rsp;
      int unsigned pos;
      pos               = 32'(r.position);
      exp_rsp.status    = ST_DONE;
      exp_rsp.entry_out = '0;
      if (r.operation == OP_INSERT) begin
        // The position check takes precedence over the full check.
        if (pos > fill) begin
          exp_rsp.status = ST_BAD_POS;
        end else if (fill >= DEPTH) begin
          exp_rsp.status = ST_FULL;
        end else begin
          if (fill >= cap) cap = (cap * 2 > DEPTH) ? DEPTH : cap * 2;
          for (int unsigned i = fill; i > pos; i--) slots[i] = slots[i-1];
          slots[pos] = r.value;
          fill++;
        end
      end else if (pos >= fill) begin
        exp_rsp.status = ST_BAD_POS;
      end else begin
        exp_rsp.entry_out = slots[pos];
        case (r.operation)
          OP_REPLACE: begin
            slots[pos] = r.value;
          end
          OP_REMOVE: begin
            for (int unsigned i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
            slots[fill-1] = '0;
            fill--;
            // Shrink once the list drops under a quarter of the capacity.
            if (fill < cap / 4) cap = (cap / 2 > MIN_CAPACITY) ? cap / 2 : MIN_CAPACITY;
          end
          default: begin
          end
        endcase
      end
      exp_rsp.entry_count  = fill[FCNT_W-1:0];
      exp_rsp.capacity_now = cap[FCNT_W-1:0];
      pending.push_back(exp_rsp);
      op_seen[r.operation]++;
      status_seen[exp_rsp.status]++;
      if (fill > peak_fill) peak_fill = fill;
      if (cap > peak_cap) peak_cap = cap;
    endfunction

    // Compare one accepted response with the oldest prediction.
    function void check_response(input plwc_rsp_t got);
      plwc_rsp_t exp_rsp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Response with no request outstanding: status %0d entry %h count %0d cap %0d",
                   got.status, got.entry_out, got.entry_count, got.capacity_now);
        return;
      end
      exp_rsp = pending.pop_front();
      if (got.status !== exp_rsp.status || got.entry_out !== exp_rsp.entry_out ||
          got.entry_count !== exp_rsp.entry_count ||
          got.capacity_now !== exp_rsp.capacity_now) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Mismatch %0d: status %0d/%0d entry %h/%h count %0d/%0d cap %0d/%0d (exp/got)",
                   mismatches, exp_rsp.status, got.status, exp_rsp.entry_out, got.entry_out,
                   exp_rsp.entry_count, got.entry_count, exp_rsp.capacity_now,
                   got.capacity_now);
      end
    endfunction
  endclass

  logic      clk_i     = 1'b0;
  logic      rst_n     = 1'b0;
  logic      req_valid = 1'b0;
  plwc_req_t req_data  = '0;
  logic      rsp_stall = 1'b0;
  logic      req_stall;
  logic      rsp_valid;
  plwc_rsp_t rsp_data;

  list_tracker tracker;
  int unsigned items_sent = 0;
  int unsigned idle_pct   = 0;
  bit          calm       = 1'b0;

  positional_list_with_capacity_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_stall_o (req_stall),
    .req_i       (req_data),
    .rsp_valid_o (rsp_valid),
    .rsp_stall_i (rsp_stall),
    .rsp_o       (rsp_data)
  );

  always #4 clk_i = ~clk_i;

  // Check every response taken at a clock edge.
  always @(posedge clk_i) begin
    if (rst_n && rsp_valid === 1'b1 && !rsp_stall) tracker.check_response(rsp_data);
  end

  // Response back-pressure in random bursts, switched off near the end.
  initial begin : rsp_stall_gen
    int unsigned burst;
    forever begin
      @(posedge clk_i);
      if (rst_n && !calm && $urandom_range(0, 99) < idle_pct / 2) begin
        burst = $urandom_range(1, 8);
        rsp_stall <= 1'b1;
        repeat (burst) @(posedge clk_i);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Hold one request until it is accepted, then maybe leave a gap.
  task automatic send_request(input plwc_req_t r);
    int unsigned gap;
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk_i);
    while (req_stall !== 1'b0) @(posedge clk_i);
    tracker.note_request(r);
    items_sent++;
    // The closing stretch of the run goes without any idling.
    calm = (items_sent + CALM_ITEMS >= DIRECTED_ITEMS + RANDOM_ITEMS);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 8);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending until every outstanding response has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending.size() != 0);
  endtask

  function automatic plwc_req_t make_req(input plwc_op_e op, input int unsigned pos,
                                         input logic [VALUE_W-1:0] word);
    plwc_req_t r;
    r.operation = op;
    r.position  = pos[POS_W-1:0];
    r.value     = word;
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] random_word();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  // Build a request biased toward the given kind of episode.
  function automatic plwc_req_t shaped_request(input episode_e kind);
    plwc_req_t   r;
    int unsigned roll;
    int unsigned fill;
    fill        = tracker.fill;
    roll        = $urandom_range(0, 99);
    r.value     = random_word();
    r.position  = POS_W'($urandom_range(0, 127));
    r.operation = plwc_op_e'($urandom_range(0, 3));
    if (kind == EP_GROW && roll < 85) r.operation = OP_INSERT;
    if (kind == EP_DRAIN && roll < 85) r.operation = OP_REMOVE;
    // Outside noise episodes most positions land inside the list.
    if (kind != EP_NOISE && $urandom_range(0, 9) != 0) begin
      if (r.operation == OP_INSERT) r.position = POS_W'($urandom_range(0, fill));
      else if (fill > 0) r.position = POS_W'($urandom_range(0, fill - 1));
    end
    return r;
  endfunction

  initial begin : main
    episode_e    kind;
    int unsigned guard;
    int unsigned pick;
    bit          first_episode;

    tracker = new();
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part: errors on an empty list, growth, every operation, shrink.
    idle_pct = 20;
    send_request(make_req(OP_ACCESS, 0, 32'h0000_0000));
    send_request(make_req(OP_REMOVE, 127, 32'h0000_0000));
    send_request(make_req(OP_REPLACE, 0, 32'hFFFF_FFFF));
    send_request(make_req(OP_INSERT, 1, 32'h1111_1111));
    send_request(make_req(OP_INSERT, 127, 32'h0000_0000));
    send_request(make_req(OP_INSERT, 0, 32'hFFFF_FFFF));
    send_request(make_req(OP_INSERT, 0, 32'h0000_0000));
    send_request(make_req(OP_INSERT, 2, 32'hA5A5_A5A5));
    send_request(make_req(OP_INSERT, 1, 32'h5A5A_5A5A));
    send_request(make_req(OP_INSERT, 4, 32'h1234_5678));
    send_request(make_req(OP_ACCESS, 4, 32'hFFFF_FFFF));
    send_request(make_req(OP_ACCESS, 5, 32'h0000_0000));
    send_request(make_req(OP_REPLACE, 0, 32'hFFFF_FFFF));
    send_request(make_req(OP_REPLACE, 5, 32'h8000_0001));
    send_request(make_req(OP_REMOVE, 2, 32'h0000_0000));
    send_request(make_req(OP_REMOVE, 3, 32'h0000_0000));
    send_request(make_req(OP_REMOVE, 0, 32'h0000_0000));
    send_request(make_req(OP_REMOVE, 0, 32'h0000_0000));
    send_request(make_req(OP_ACCESS, 0, 32'h0000_0000));
    send_request(make_req(OP_REMOVE, 0, 32'h0000_0000));
    send_request(make_req(OP_REMOVE, 0, 32'hFFFF_FFFF));
    send_request(make_req(OP_REPLACE, 127, 32'hFFFF_FFFF));
    wait_drained();

    // Random part in episodes; the first one fills the list to the top.
    first_episode = 1'b1;
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      calm = (items_sent + CALM_ITEMS >= DIRECTED_ITEMS + RANDOM_ITEMS);
      pick = $urandom_range(0, 3);
      idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 30 : 60;
      pick = $urandom_range(0, 99);
      if (first_episode) kind = EP_GROW;
      else if (pick < 30) kind = EP_GROW;
      else if (pick < 60) kind = EP_DRAIN;
      else if (pick < 85) kind = EP_MIXED;
      else kind = EP_NOISE;
      first_episode = 1'b0;
      guard = 0;
      case (kind)
        EP_GROW: begin
          while (tracker.fill < DEPTH && guard < 400) begin
            send_request(shaped_request(EP_GROW));
            guard++;
          end
          // Probe the full list with inserts and other operations.
          repeat ($urandom_range(3, 8)) send_request(shaped_request(EP_MIXED));
        end
        EP_DRAIN: begin
          while (tracker.fill > 0 && guard < 400) begin
            send_request(shaped_request(EP_DRAIN));
            guard++;
          end
          repeat ($urandom_range(2, 5)) send_request(shaped_request(EP_NOISE));
        end
        EP_MIXED: begin
          repeat ($urandom_range(20, 80)) send_request(shaped_request(EP_MIXED));
        end
        default: begin
          repeat ($urandom_range(5, 30)) send_request(shaped_request(EP_NOISE));
        end
      endcase
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("Ran %0d requests: %0d inserts, %0d replaces, %0d accesses, %0d removes.",
             items_sent, tracker.op_seen[OP_INSERT], tracker.op_seen[OP_REPLACE],
             tracker.op_seen[OP_ACCESS], tracker.op_seen[OP_REMOVE]);
    $display("Outcomes: %0d done, %0d bad position, %0d full; peak %0d entries, capacity %0d.",
             tracker.status_seen[ST_DONE], tracker.status_seen[ST_BAD_POS],
             tracker.status_seen[ST_FULL], tracker.peak_fill, tracker.peak_cap);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches in total.", tracker.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin : run_limit
    #4000000;
    $display("Run limit reached with %0d responses outstanding.", tracker.pending.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
